// ===== rtl/t4t_pkg.sv =====
// Shared types, codes and constants of the Type 4 tag NDEF responder.
// Used by t4t_ctrl, t4t_dp and type4_tag_ndef_responder; depends on nothing.
`default_nettype none

package t4t_pkg;

	// Default record store depth in bytes
	localparam int RECORD_DEPTH_DEF = 4096;

	// Input command codes
	localparam logic [1:0] CMD_LOAD = 2'd0;
	localparam logic [1:0] CMD_APDU = 2'd1;
	localparam logic [1:0] CMD_ACT  = 2'd2;

	// Command patterns, first byte in the most significant position
	localparam logic [95:0] APP_SELECT_PAT  = 96'h00A4_0400_07D2_7600_0085_0101;
	localparam logic [55:0] CC_SELECT_PAT   = 56'h00A4_000C_02E1_03;
	localparam logic [55:0] NDEF_SELECT_PAT = 56'h00A4_000C_02E1_04;
	localparam logic [15:0] READ_BINARY_PAT = 16'h00B0;

	// Status words
	localparam logic [7:0] SW_OK_HI   = 8'h90;
	localparam logic [7:0] SW_OK_LO   = 8'h00;
	localparam logic [7:0] SW_FAIL_HI = 8'h6A;
	localparam logic [7:0] SW_FAIL_LO = 8'h82;

	// Length of the capability container file
	localparam logic [7:0] CC_LEN = 8'h0F;

	typedef enum logic [1:0] {
		SESS_READY = 2'd0,
		SESS_APP   = 2'd1,
		SESS_CC    = 2'd2,
		SESS_NDEF  = 2'd3
	} sess_t;

	// Source of the data bytes of a response
	typedef enum logic [1:0] {
		SRC_NONE = 2'd0,
		SRC_CC   = 2'd1,
		SRC_FILE = 2'd2
	} src_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_FILL,
		S_LAST,
		S_EMIT
	} ctrl_state_t;

	// Controller to datapath
	typedef struct packed {
		logic decode;
		logic issue;
		logic emit;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic in_apdu;
		logic beat_end;
		logic resp_done;
		logic out_free;
	} dp_status_t;

	// Fixed capability container bytes
	function automatic logic [7:0] cc_file_byte(input logic [3:0] idx);
		logic [7:0] b;
		unique case (idx)
			4'd0:    b = 8'h00;
			4'd1:    b = 8'h0F;
			4'd2:    b = 8'h20;
			4'd3:    b = 8'h00;
			4'd4:    b = 8'hFF;
			4'd5:    b = 8'h00;
			4'd6:    b = 8'hFF;
			4'd7:    b = 8'h04;
			4'd8:    b = 8'h06;
			4'd9:    b = 8'hE1;
			4'd10:   b = 8'h04;
			4'd11:   b = 8'h00;
			4'd12:   b = 8'hFF;
			4'd13:   b = 8'h00;
			4'd14:   b = 8'hFF;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/t4t_ctrl.sv =====
// Sequencing state machine of the Type 4 tag responder.
// Depends on t4t_pkg; drives t4t_dp through command and status structs.
`default_nettype none

module t4t_ctrl (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    in_valid,
	output logic                   in_ready,
	input  wire t4t_pkg::dp_status_t st,
	output t4t_pkg::dp_cmd_t       cmd
);
	import t4t_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d    = state_q;
		cmd.decode = 1'b0;
		cmd.issue  = 1'b0;
		cmd.emit   = 1'b0;
		in_ready   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && st.in_apdu) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				cmd.decode = 1'b1;
				state_d    = S_FILL;
			end
			S_FILL: begin
				// issue one byte a cycle until the beat is complete
				cmd.issue = 1'b1;
				if (st.beat_end) begin
					state_d = S_LAST;
				end
			end
			S_LAST: begin
				// let the final byte of the beat land
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (st.out_free) begin
					cmd.emit = 1'b1;
					state_d  = st.resp_done ? S_IDLE : S_FILL;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/t4t_dp.sv =====
// Datapath of the Type 4 tag responder: record memory, command decode,
// session register, byte sequencing, beat assembly and output register.
// Depends on t4t_pkg; controlled by t4t_ctrl.
`default_nettype none

module t4t_dp #(
	parameter int RECORD_DEPTH = t4t_pkg::RECORD_DEPTH_DEF
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    cfg_wr_en,
	input  wire  [12:0]            cfg_wr_data,
	input  wire                    in_fire,
	input  wire  [1:0]             command,
	input  wire  [11:0]            record_addr,
	input  wire  [7:0]             record_byte,
	input  wire  [63:0]            apdu_head,
	input  wire  [31:0]            apdu_tail,
	output logic                   out_valid,
	input  wire                    out_ready,
	output logic [63:0]            resp_bytes,
	output logic [3:0]             resp_count,
	output logic                   resp_last,
	output logic                   resp_ok,
	output logic                   record_sent,
	input  wire t4t_pkg::dp_cmd_t  cmd,
	output t4t_pkg::dp_status_t    st
);
	import t4t_pkg::*;

	localparam int          AW      = $clog2(RECORD_DEPTH);
	localparam logic [16:0] DEPTH_W = 17'(RECORD_DEPTH);

	logic [7:0]  mem [RECORD_DEPTH];

	logic [12:0] record_size_q;
	sess_t       sess_q;
	logic [95:0] apdu_q;

	logic        ok_q;
	logic        sent_q;
	src_t        src_q;
	logic [7:0]  data_len_q;
	logic [8:0]  resp_len_q;
	logic [8:0]  pos_q;
	logic [16:0] file_pos_q;
	logic [3:0]  slot_q;
	logic [63:0] beat_q;

	logic        cap_v_s1;
	logic [2:0]  cap_slot_s1;
	logic        use_mem_s1;
	logic [7:0]  byp_s1;
	logic [7:0]  rdata_s1;

	// Decode signals
	logic        app_match;
	logic        cc_match;
	logic        ndef_match;
	logic        read_match;
	logic [15:0] rd_offset;
	logic [7:0]  rd_length;
	logic [16:0] rd_end;
	logic [16:0] rd_limit;
	logic        dec_ok;
	logic        dec_sent;
	src_t        dec_src;
	logic [7:0]  dec_len;
	sess_t       dec_sess;

	// Issue signals
	logic [16:0] load_addr;
	logic [16:0] mem_idx;
	logic        mem_hit;
	logic        iss_use_mem;
	logic [7:0]  iss_byte;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			record_size_q <= '0;
		end else if (cfg_wr_en) begin
			record_size_q <= cfg_wr_data;
		end
	end

	// Record memory: loads write, sequencer reads with registered data
	assign load_addr = {5'd0, record_addr};

	always_ff @(posedge clk) begin
		if (in_fire && command == CMD_LOAD && load_addr < DEPTH_W) begin
			mem[load_addr[AW-1:0]] <= record_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			rdata_s1 <= mem[mem_idx[AW-1:0]];
		end
	end

	// Hold the command APDU
	always_ff @(posedge clk) begin
		if (in_fire && command == CMD_APDU) begin
			apdu_q <= {apdu_head, apdu_tail};
		end
	end

	// Match the command against the known patterns
	always_comb begin
		app_match  = (apdu_q == APP_SELECT_PAT);
		cc_match   = (apdu_q[95:40] == CC_SELECT_PAT);
		ndef_match = (apdu_q[95:40] == NDEF_SELECT_PAT);
		read_match = (apdu_q[95:80] == READ_BINARY_PAT);
		rd_offset  = apdu_q[79:64];
		rd_length  = apdu_q[63:56];
		rd_end     = {1'b0, rd_offset} + {9'd0, rd_length};
		rd_limit   = {4'd0, record_size_q} + 17'd2;

		dec_ok   = 1'b0;
		dec_sent = 1'b0;
		dec_src  = SRC_NONE;
		dec_len  = 8'd0;
		dec_sess = sess_q;
		priority if (app_match) begin
			dec_ok   = 1'b1;
			dec_sess = SESS_APP;
		end else if (cc_match) begin
			if (sess_q == SESS_APP) begin
				dec_ok   = 1'b1;
				dec_sess = SESS_CC;
			end
		end else if (ndef_match) begin
			dec_ok   = 1'b1;
			dec_sess = SESS_NDEF;
		end else if (read_match) begin
			if (sess_q == SESS_CC) begin
				dec_ok  = 1'b1;
				dec_src = SRC_CC;
				dec_len = CC_LEN;
			end else if (sess_q == SESS_NDEF && rd_end <= rd_limit) begin
				dec_ok   = 1'b1;
				dec_src  = SRC_FILE;
				dec_len  = rd_length;
				dec_sent = (rd_end >= rd_limit);
			end
		end
		// a failed command drops the session
		if (!dec_ok) begin
			dec_sess = SESS_READY;
		end
	end

	// Session register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sess_q <= SESS_READY;
		end else if (in_fire && command == CMD_ACT) begin
			sess_q <= SESS_READY;
		end else if (cmd.decode) begin
			sess_q <= dec_sess;
		end
	end

	// Response description, latched at decode
	always_ff @(posedge clk) begin
		if (cmd.decode) begin
			ok_q       <= dec_ok;
			sent_q     <= dec_sent;
			src_q      <= dec_src;
			data_len_q <= dec_len;
			resp_len_q <= {1'b0, dec_len} + 9'd2;
		end
	end

	// Select the byte at the current response position
	assign mem_idx = file_pos_q - 17'd2;
	assign mem_hit = (file_pos_q >= 17'd2) && (mem_idx < DEPTH_W);

	always_comb begin
		iss_use_mem = 1'b0;
		iss_byte    = 8'h00;
		if (pos_q < {1'b0, data_len_q}) begin
			if (src_q == SRC_CC) begin
				iss_byte = cc_file_byte(pos_q[3:0]);
			end else if (file_pos_q == 17'd0) begin
				iss_byte = {3'd0, record_size_q[12:8]};
			end else if (file_pos_q == 17'd1) begin
				iss_byte = record_size_q[7:0];
			end else begin
				iss_use_mem = mem_hit;
			end
		end else if (pos_q == {1'b0, data_len_q}) begin
			iss_byte = ok_q ? SW_OK_HI : SW_FAIL_HI;
		end else begin
			iss_byte = ok_q ? SW_OK_LO : SW_FAIL_LO;
		end
	end

	// Advance the byte position
	always_ff @(posedge clk) begin
		if (cmd.decode) begin
			pos_q      <= '0;
			file_pos_q <= {1'b0, rd_offset};
		end else if (cmd.issue) begin
			pos_q      <= pos_q + 9'd1;
			file_pos_q <= file_pos_q + 17'd1;
		end
	end

	// Fill slot counter of the beat being built
	always_ff @(posedge clk) begin
		if (cmd.decode || cmd.emit) begin
			slot_q <= '0;
		end else if (cmd.issue) begin
			slot_q <= slot_q + 4'd1;
		end
	end

	// Read stage: carry the byte choice alongside the memory read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_v_s1 <= 1'b0;
		end else begin
			cap_v_s1 <= cmd.issue;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			cap_slot_s1 <= slot_q[2:0];
			use_mem_s1  <= iss_use_mem;
			byp_s1      <= iss_byte;
		end
	end

	// Assemble the beat, first byte in the top slot
	always_ff @(posedge clk) begin
		if (cmd.decode || cmd.emit) begin
			beat_q <= '0;
		end else if (cap_v_s1) begin
			beat_q[63 - 8*cap_slot_s1 -: 8] <= use_mem_s1 ? rdata_s1 : byp_s1;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.emit) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			resp_bytes  <= beat_q;
			resp_count  <= slot_q;
			resp_last   <= (pos_q == resp_len_q);
			resp_ok     <= ok_q;
			record_sent <= sent_q;
		end
	end

	// Status to the controller
	always_comb begin
		st.in_apdu   = (command == CMD_APDU);
		st.beat_end  = (slot_q == 4'd7) || (pos_q + 9'd1 == resp_len_q);
		st.resp_done = (pos_q == resp_len_q);
		st.out_free  = !out_valid || out_ready;
	end

endmodule

`default_nettype wire

// ===== rtl/type4_tag_ndef_responder.sv =====
// NFC Type 4 tag NDEF responder, card side: top level.
// Depends on t4t_pkg; instantiates t4t_ctrl and t4t_dp.
//
// Load and field activation items are taken while the responder is idle. A
// command APDU is accepted, then decoded, and then builds its response one
// byte a cycle from the byte-wide record memory, pausing after each 8-byte
// beat until it moves into the output register, which waits while the sink
// holds out_ready low. A new item is accepted once the last beat of the
// previous response has moved into the output register.
`default_nettype none

module type4_tag_ndef_responder #(
	parameter int RECORD_DEPTH = t4t_pkg::RECORD_DEPTH_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_wr_en,
	input  wire  [12:0] cfg_wr_data,
	input  wire         in_valid,
	output logic        in_ready,
	input  wire  [1:0]  command,
	input  wire  [11:0] record_addr,
	input  wire  [7:0]  record_byte,
	input  wire  [63:0] apdu_head,
	input  wire  [31:0] apdu_tail,
	output logic        out_valid,
	input  wire         out_ready,
	output logic [63:0] resp_bytes,
	output logic [3:0]  resp_count,
	output logic        resp_last,
	output logic        resp_ok,
	output logic        record_sent
);
	import t4t_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t st;
	logic       in_fire;

	// Input transfer
	assign in_fire = in_valid && in_ready;

	t4t_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	t4t_dp #(
		.RECORD_DEPTH (RECORD_DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_fire     (in_fire),
		.command     (command),
		.record_addr (record_addr),
		.record_byte (record_byte),
		.apdu_head   (apdu_head),
		.apdu_tail   (apdu_tail),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.resp_bytes  (resp_bytes),
		.resp_count  (resp_count),
		.resp_last   (resp_last),
		.resp_ok     (resp_ok),
		.record_sent (record_sent),
		.cmd         (cmd),
		.st          (st)
	);

endmodule

`default_nettype wire
